@@ sv/plen_pkg.sv @@
// ----------------------------------------------------------------------------
// plen_pkg: shared types, codes and microprogram for the positional list engine
// Holds the request and result item types, the control word layout and the
// read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package plen_pkg;

    localparam int CAPACITY   = 256;
    localparam int ITEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int UPC_W      = 4;

    // Operation codes.
    localparam logic [1:0] OP_RETRIEVE = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Microprogram addresses.
    localparam logic [UPC_W-1:0] UA_IDLE      = 4'd0;
    localparam logic [UPC_W-1:0] UA_DISPATCH  = 4'd1;
    localparam logic [UPC_W-1:0] UA_RETR      = 4'd2;
    localparam logic [UPC_W-1:0] UA_INS_A     = 4'd3;
    localparam logic [UPC_W-1:0] UA_INS_B     = 4'd4;
    localparam logic [UPC_W-1:0] UA_INS_C     = 4'd5;
    localparam logic [UPC_W-1:0] UA_REM_A     = 4'd6;
    localparam logic [UPC_W-1:0] UA_REM_B     = 4'd7;
    localparam logic [UPC_W-1:0] UA_REM_C     = 4'd8;
    localparam logic [UPC_W-1:0] UA_CLR       = 4'd9;
    localparam logic [UPC_W-1:0] UA_RESP_ZERO = 4'd10;
    localparam logic [UPC_W-1:0] UA_RESP_READ = 4'd11;

    // Read address select.
    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_POSM1 = 2'd1;
    localparam logic [1:0] RD_PNM1  = 2'd2;
    localparam logic [1:0] RD_PN    = 2'd3;

    // Write select.
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_PTR   = 2'd1;
    localparam logic [1:0] WR_PTRM1 = 2'd2;
    localparam logic [1:0] WR_ITEM  = 2'd3;

    // Pointer operation.
    localparam logic [2:0] P_HOLD = 3'd0;
    localparam logic [2:0] P_CNT  = 3'd1;
    localparam logic [2:0] P_POS  = 3'd2;
    localparam logic [2:0] P_INC  = 3'd3;
    localparam logic [2:0] P_DEC  = 3'd4;

    // Count operation.
    localparam logic [1:0] C_HOLD = 2'd0;
    localparam logic [1:0] C_INC  = 2'd1;
    localparam logic [1:0] C_DEC  = 2'd2;
    localparam logic [1:0] C_CLR  = 2'd3;

    // Sequencing.
    localparam logic [2:0] SQ_WAIT     = 3'd0;
    localparam logic [2:0] SQ_GOTO     = 3'd1;
    localparam logic [2:0] SQ_DISPATCH = 3'd2;
    localparam logic [2:0] SQ_IF_POSM1 = 3'd3;
    localparam logic [2:0] SQ_IF_CNT   = 3'd4;

    // Result emission.
    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_ZERO = 2'd1;
    localparam logic [1:0] EM_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [8:0]  position;
        logic [31:0] item_value;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [8:0]  list_length;
    } result_t;

    typedef struct packed {
        logic [1:0]       rd_sel;
        logic [1:0]       wr_sel;
        logic [2:0]       ptr_op;
        logic [1:0]       cnt_op;
        logic [2:0]       seq;
        logic [1:0]       emit;
        logic [UPC_W-1:0] target;
        logic [UPC_W-1:0] alt;
    } ctrl_t;

    typedef struct packed {
        logic             pn_eq_posm1;
        logic             pn_eq_cnt;
        logic [UPC_W-1:0] disp_target;
    } flags_t;

    // The microprogram. Conditional steps go to target when the test holds
    // and to alt otherwise.
    function automatic ctrl_t ucode_word(input logic [UPC_W-1:0] upc);
        ctrl_t w;
        w        = '0;
        w.rd_sel = RD_NONE;
        w.wr_sel = WR_NONE;
        w.ptr_op = P_HOLD;
        w.cnt_op = C_HOLD;
        w.seq    = SQ_GOTO;
        w.emit   = EM_NONE;
        w.target = UA_IDLE;
        w.alt    = UA_IDLE;
        case (upc)
            UA_IDLE: begin
                w.seq    = SQ_WAIT;
                w.target = UA_DISPATCH;
            end
            UA_DISPATCH: begin
                w.seq = SQ_DISPATCH;
            end
            UA_RETR: begin
                w.rd_sel = RD_POSM1;
                w.target = UA_RESP_READ;
            end
            UA_INS_A: begin
                w.ptr_op = P_CNT;
                w.rd_sel = RD_PNM1;
                w.seq    = SQ_IF_POSM1;
                w.target = UA_INS_C;
                w.alt    = UA_INS_B;
            end
            UA_INS_B: begin
                w.wr_sel = WR_PTR;
                w.ptr_op = P_DEC;
                w.rd_sel = RD_PNM1;
                w.seq    = SQ_IF_POSM1;
                w.target = UA_INS_C;
                w.alt    = UA_INS_B;
            end
            UA_INS_C: begin
                w.wr_sel = WR_ITEM;
                w.cnt_op = C_INC;
                w.target = UA_RESP_ZERO;
            end
            UA_REM_A: begin
                w.ptr_op = P_POS;
                w.rd_sel = RD_PN;
                w.seq    = SQ_IF_CNT;
                w.target = UA_REM_C;
                w.alt    = UA_REM_B;
            end
            UA_REM_B: begin
                w.wr_sel = WR_PTRM1;
                w.ptr_op = P_INC;
                w.rd_sel = RD_PN;
                w.seq    = SQ_IF_CNT;
                w.target = UA_REM_C;
                w.alt    = UA_REM_B;
            end
            UA_REM_C: begin
                w.cnt_op = C_DEC;
                w.target = UA_RESP_ZERO;
            end
            UA_CLR: begin
                w.cnt_op = C_CLR;
                w.target = UA_RESP_ZERO;
            end
            UA_RESP_ZERO: begin
                w.emit = EM_ZERO;
            end
            UA_RESP_READ: begin
                w.emit = EM_READ;
            end
            default: begin
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/plen_sequencer.sv @@
// ----------------------------------------------------------------------------
// plen_sequencer: microprogram counter and next-address logic
// Fetches the control word for the current step and picks the next step from
// the jump field and the datapath condition flags.
// ----------------------------------------------------------------------------
module plen_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  plen_pkg::flags_t flags,
    output plen_pkg::ctrl_t  ctrl,
    output logic             busy
);

    logic [plen_pkg::UPC_W-1:0] upc_reg;
    logic [plen_pkg::UPC_W-1:0] upc_next;

    assign ctrl = plen_pkg::ucode_word(upc_reg);
    assign busy = (upc_reg != plen_pkg::UA_IDLE);

    always_comb
    begin
        unique case (ctrl.seq)
            plen_pkg::SQ_WAIT:     upc_next = accept ? ctrl.target : upc_reg;
            plen_pkg::SQ_GOTO:     upc_next = ctrl.target;
            plen_pkg::SQ_DISPATCH: upc_next = flags.disp_target;
            plen_pkg::SQ_IF_POSM1: upc_next = flags.pn_eq_posm1 ? ctrl.target : ctrl.alt;
            plen_pkg::SQ_IF_CNT:   upc_next = flags.pn_eq_cnt ? ctrl.target : ctrl.alt;
            default:               upc_next = plen_pkg::UA_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= plen_pkg::UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ sv/plen_datapath.sv @@
// ----------------------------------------------------------------------------
// plen_datapath: entry memory, pointer, count and result registers
// Carries out the control word of each step: one memory read and one write per
// cycle, pointer and count updates, request checks and result loading.
// ----------------------------------------------------------------------------
module plen_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  plen_pkg::request_t request,
    input  plen_pkg::ctrl_t    ctrl,
    output plen_pkg::flags_t   flags,
    output logic               done,
    output plen_pkg::result_t  result
);

    logic [plen_pkg::ITEM_WIDTH-1:0] mem [plen_pkg::CAPACITY];

    plen_pkg::request_t              req_reg;
    logic [plen_pkg::CNT_W-1:0]      cnt_reg;
    logic [plen_pkg::CNT_W-1:0]      cnt_next;
    logic [plen_pkg::CNT_W-1:0]      ptr_reg;
    logic [plen_pkg::CNT_W-1:0]      ptr_next;
    logic [1:0]                      status_reg;
    logic [1:0]                      status_next;
    logic [plen_pkg::ITEM_WIDTH-1:0] rdata_reg;
    plen_pkg::result_t               result_reg;
    plen_pkg::result_t               result_next;
    logic                            done_reg;

    logic [plen_pkg::CNT_W-1:0]      posm1;
    logic [plen_pkg::CNT_W-1:0]      rd_idx;
    logic [plen_pkg::CNT_W-1:0]      wr_idx;
    logic [plen_pkg::ITEM_WIDTH-1:0] wr_data;
    logic                            rd_en;
    logic                            wr_en;
    logic                            pos_zero;
    logic                            past_end;
    logic                            past_tail;
    logic                            is_full;

    assign posm1 = req_reg.position - 9'd1;

    always_comb
    begin
        unique case (ctrl.ptr_op)
            plen_pkg::P_HOLD: ptr_next = ptr_reg;
            plen_pkg::P_CNT:  ptr_next = cnt_reg;
            plen_pkg::P_POS:  ptr_next = req_reg.position;
            plen_pkg::P_INC:  ptr_next = ptr_reg + 9'd1;
            plen_pkg::P_DEC:  ptr_next = ptr_reg - 9'd1;
            default:          ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.cnt_op)
            plen_pkg::C_HOLD: cnt_next = cnt_reg;
            plen_pkg::C_INC:  cnt_next = cnt_reg + 9'd1;
            plen_pkg::C_DEC:  cnt_next = cnt_reg - 9'd1;
            plen_pkg::C_CLR:  cnt_next = '0;
            default:          cnt_next = cnt_reg;
        endcase
    end

    // Request checks, used by the dispatch step.
    assign pos_zero  = (req_reg.position == 9'd0);
    assign past_end  = (req_reg.position > cnt_reg);
    assign past_tail = ({1'b0, req_reg.position} > ({1'b0, cnt_reg} + 10'd1));
    assign is_full   = (cnt_reg == plen_pkg::CNT_W'(plen_pkg::CAPACITY));

    always_comb
    begin
        flags.pn_eq_posm1 = (ptr_next == posm1);
        flags.pn_eq_cnt   = (ptr_next == cnt_reg);
        unique case (req_reg.operation)
            plen_pkg::OP_RETRIEVE:
            begin
                status_next       = (pos_zero || past_end) ? plen_pkg::ST_RANGE
                                                           : plen_pkg::ST_OK;
                flags.disp_target = (pos_zero || past_end) ? plen_pkg::UA_RESP_ZERO
                                                           : plen_pkg::UA_RETR;
            end
            plen_pkg::OP_INSERT:
            begin
                if (pos_zero || past_tail)
                begin
                    status_next       = plen_pkg::ST_RANGE;
                    flags.disp_target = plen_pkg::UA_RESP_ZERO;
                end
                else if (is_full)
                begin
                    status_next       = plen_pkg::ST_FULL;
                    flags.disp_target = plen_pkg::UA_RESP_ZERO;
                end
                else
                begin
                    status_next       = plen_pkg::ST_OK;
                    flags.disp_target = plen_pkg::UA_INS_A;
                end
            end
            plen_pkg::OP_REMOVE:
            begin
                status_next       = (pos_zero || past_end) ? plen_pkg::ST_RANGE
                                                           : plen_pkg::ST_OK;
                flags.disp_target = (pos_zero || past_end) ? plen_pkg::UA_RESP_ZERO
                                                           : plen_pkg::UA_REM_A;
            end
            default:
            begin
                status_next       = plen_pkg::ST_OK;
                flags.disp_target = plen_pkg::UA_CLR;
            end
        endcase
    end

    always_comb
    begin
        rd_en  = 1'b1;
        rd_idx = ptr_next;
        unique case (ctrl.rd_sel)
            plen_pkg::RD_NONE:  rd_en  = 1'b0;
            plen_pkg::RD_POSM1: rd_idx = posm1;
            plen_pkg::RD_PNM1:  rd_idx = ptr_next - 9'd1;
            plen_pkg::RD_PN:    rd_idx = ptr_next;
            default:            rd_en  = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_idx  = ptr_reg;
        wr_data = rdata_reg;
        unique case (ctrl.wr_sel)
            plen_pkg::WR_NONE:  wr_en  = 1'b0;
            plen_pkg::WR_PTR:   wr_idx = ptr_reg;
            plen_pkg::WR_PTRM1: wr_idx = ptr_reg - 9'd1;
            plen_pkg::WR_ITEM:
            begin
                wr_idx  = posm1;
                wr_data = req_reg.item_value;
            end
            default:            wr_en  = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[plen_pkg::ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx[plen_pkg::ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        result_next.status      = status_reg;
        result_next.list_length = cnt_reg;
        result_next.read_value  = (ctrl.emit == plen_pkg::EM_READ) ? rdata_reg : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (ctrl.seq == plen_pkg::SQ_DISPATCH)
        begin
            status_reg <= status_next;
        end
        if (ctrl.emit != plen_pkg::EM_NONE)
        begin
            result_reg <= result_next;
        end
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= (ctrl.emit != plen_pkg::EM_NONE);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of items addressed by position
// Top level of the microcoded list engine: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Usage: drive request (operation, position, item_value) and raise start. The
// item is taken at a rising edge where start is high and busy is low; busy then
// stays high until the engine is ready for the next item. Each item gives one
// result on result (status, read_value, list_length), shown for exactly one
// cycle with done high. The receiver cannot hold results off, so the engine
// never waits on the output side; the result register lets a new item be
// taken in the same cycle that done is shown.
// Each request passes the dispatch step, the steps of its operation and a
// result step; a rejected request goes from dispatch straight to the result
// step. Insert at position p moves count - p + 1 entries up one place before
// it writes the item; remove at position p moves count - p entries down one
// place. The shift loops move one entry per cycle through the
// single-port-write entry memory, so a worst-case insert or remove moves 255
// entries. Reset empties the list and clears the sequencer; the entry
// memory itself is not cleared, because entries are read only after they
// have been written.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  plen_pkg::request_t request,
    output logic               done,
    output plen_pkg::result_t  result
);

    plen_pkg::ctrl_t  ctrl;
    plen_pkg::flags_t flags;
    logic             accept;

    // A new item enters only while the sequencer sits in its idle step.
    assign accept = start && !busy;

    plen_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .flags  (flags),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    plen_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .ctrl    (ctrl),
        .flags   (flags),
        .done    (done),
        .result  (result)
    );

    // The result step always returns to idle, so a result never overlaps work.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the engine is busy");

    // The list never grows beyond its capacity.
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.list_length <= 9'(plen_pkg::CAPACITY)))
        else $error("list length beyond capacity");

    // A full status only comes back from a list at capacity.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == plen_pkg::ST_FULL))
            |-> (result.list_length == 9'(plen_pkg::CAPACITY)))
        else $error("full status with room left");

    // Failed requests read back zero.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != plen_pkg::ST_OK)) |-> (result.read_value == 32'd0))
        else $error("nonzero data on a failed request");

endmodule
